// ===== rtl/nvrm_pkg.sv =====
// Shared types, codes and constants for the virtqueue ring manager.
`timescale 1ns / 1ps

package nvrm_pkg;

    localparam int DEF_RING_DEPTH   = 8;
    localparam int DEF_HEADER_BYTES = 10;

    localparam int SIZE_W  = 4;
    localparam int MAXF_W  = 11;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int OPC_W   = 2;
    localparam int STAT_W  = 3;
    localparam int NTF_W   = 2;
    localparam int RSLOT_W = 3;
    localparam int WORD_W  = 16;
    localparam int LEN_W   = 32;

    localparam logic [SIZE_W-1:0] RX_SIZE_RST = 4'd8;
    localparam logic [SIZE_W-1:0] TX_SIZE_RST = 4'd8;
    localparam logic [MAXF_W-1:0] MAXF_RST    = 11'd1514;

    localparam logic [CIDX_W-1:0] CFG_RX_SIZE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TX_SIZE = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MAXF    = 2'd2;

    localparam logic [OPC_W-1:0] OP_RX_USED = 2'd0;
    localparam logic [OPC_W-1:0] OP_POLL    = 2'd1;
    localparam logic [OPC_W-1:0] OP_SEND    = 2'd2;

    localparam logic [STAT_W-1:0] ST_QUEUED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd1;
    localparam logic [STAT_W-1:0] ST_TX_FULL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DESC_OOR  = 3'd3;
    localparam logic [STAT_W-1:0] ST_RECYCLED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE      = 3'd5;
    localparam logic [STAT_W-1:0] ST_RETURNED  = 3'd6;

    localparam logic [NTF_W-1:0] NTF_NONE = 2'd0;
    localparam logic [NTF_W-1:0] NTF_RX   = 2'd1;
    localparam logic [NTF_W-1:0] NTF_TX   = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

// ===== rtl/nvrm_ctrl.sv =====
// Sequencing controller: item intake, FIFO read slot, execute and output handshake.
`timescale 1ns / 1ps

module nvrm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output nvrm_pkg::ctl_cmd_t cmd
);
    import nvrm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.execute = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/nvrm_datapath.sv =====
// Datapath: configuration, ring indexes, completion FIFO memory and result register.
`timescale 1ns / 1ps

module nvrm_datapath
#(
    parameter int RING_DEPTH   = nvrm_pkg::DEF_RING_DEPTH,
    parameter int HEADER_BYTES = nvrm_pkg::DEF_HEADER_BYTES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nvrm_pkg::ctl_cmd_t                cmd,
    input  logic                              cfg_we,
    input  logic [nvrm_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [nvrm_pkg::CFG_W-1:0]        cfg_data,
    input  logic [nvrm_pkg::OPC_W-1:0]        opcode,
    input  logic [nvrm_pkg::WORD_W-1:0]       desc_id,
    input  logic [nvrm_pkg::LEN_W-1:0]        used_len,
    input  logic [nvrm_pkg::WORD_W-1:0]       frame_length,
    input  logic [nvrm_pkg::WORD_W-1:0]       device_used_idx,
    output logic [nvrm_pkg::STAT_W-1:0]       status,
    output logic [nvrm_pkg::WORD_W-1:0]       slot_or_desc,
    output logic [nvrm_pkg::WORD_W-1:0]       length_out,
    output logic                              ring_write,
    output logic [nvrm_pkg::RSLOT_W-1:0]      ring_slot,
    output logic [nvrm_pkg::RSLOT_W-1:0]      ring_value,
    output logic [nvrm_pkg::NTF_W-1:0]        notify_queue,
    output logic                              rx_pending,
    output logic                              has_payload
);
    import nvrm_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CMP_W = SIZE_W + 1;
    localparam logic [8:0] DEPTH_V = 9'(RING_DEPTH);
    localparam logic [LEN_W-1:0] HDR_L = LEN_W'(HEADER_BYTES);
    localparam logic [WORD_W-1:0] HDR_W = WORD_W'(HEADER_BYTES);

    logic [SIZE_W-1:0] rx_size_reg;
    logic [SIZE_W-1:0] tx_size_reg;
    logic [MAXF_W-1:0] maxf_reg;
    logic [SIZE_W-1:0] rx_slot_reg;
    logic [SIZE_W-1:0] rx_slot_next;
    logic [SIZE_W-1:0] tx_slot_reg;
    logic [SIZE_W-1:0] tx_slot_next;
    logic [WORD_W-1:0] rx_avail_reg;
    logic [WORD_W-1:0] rx_avail_next;
    logic [WORD_W-1:0] tx_avail_reg;
    logic [WORD_W-1:0] tx_avail_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [IDX_W-1:0]  tail_reg;
    logic [IDX_W-1:0]  tail_next;
    logic [SIZE_W-1:0] count_reg;
    logic [SIZE_W-1:0] count_next;
    logic              push;

    logic [OPC_W-1:0]  opc_reg;
    logic [WORD_W-1:0] desc_reg;
    logic [LEN_W-1:0]  ulen_reg;
    logic [WORD_W-1:0] flen_reg;
    logic [WORD_W-1:0] dused_reg;

    logic [SIZE_W-1:0] desc_mem [RING_DEPTH];
    logic [LEN_W-1:0]  len_mem  [RING_DEPTH];
    logic [SIZE_W-1:0] rd_desc_reg;
    logic [LEN_W-1:0]  rd_len_reg;

    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [WORD_W-1:0]  sod_reg;
    logic [WORD_W-1:0]  sod_next;
    logic [WORD_W-1:0]  lout_reg;
    logic [WORD_W-1:0]  lout_next;
    logic               rw_reg;
    logic               rw_next;
    logic [RSLOT_W-1:0] rslot_reg;
    logic [RSLOT_W-1:0] rslot_next;
    logic [RSLOT_W-1:0] rval_reg;
    logic [RSLOT_W-1:0] rval_next;
    logic [NTF_W-1:0]   ntf_reg;
    logic [NTF_W-1:0]   ntf_next;
    logic               pend_reg;
    logic               haspay_reg;
    logic               haspay_next;

    logic [SIZE_W-1:0] rxs;
    logic [SIZE_W-1:0] txs;
    logic [LEN_W-1:0]  pay_full;
    logic [MAXF_W-1:0] pay_clamp;
    logic [WORD_W-1:0] outstanding;
    logic [CMP_W-1:0]  tail_inc;
    logic [CMP_W-1:0]  head_inc;
    logic [CMP_W-1:0]  rx_slot_inc;
    logic [CMP_W-1:0]  tx_slot_inc;
    logic [WORD_W-1:0] rx_avail_inc;
    logic [WORD_W-1:0] tx_avail_inc;
    logic [SIZE_W-1:0] rx_slot_adv;
    logic [SIZE_W-1:0] tx_slot_adv;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (9'(v) > DEPTH_V)
        begin
            r = DEPTH_V[SIZE_W-1:0];
        end
        return r;
    endfunction

    assign rxs = eff_size(rx_size_reg);
    assign txs = eff_size(tx_size_reg);

    assign tail_inc    = CMP_W'(tail_reg) + CMP_W'(1);
    assign head_inc    = CMP_W'(head_reg) + CMP_W'(1);
    assign rx_slot_inc = CMP_W'(rx_slot_reg) + CMP_W'(1);
    assign tx_slot_inc = CMP_W'(tx_slot_reg) + CMP_W'(1);
    assign outstanding = tx_avail_reg - dused_reg;

    // The ring slot follows the 16-bit avail index modulo the ring size, so it
    // restarts at zero when that index wraps.
    assign rx_avail_inc = rx_avail_reg + WORD_W'(1);
    assign tx_avail_inc = tx_avail_reg + WORD_W'(1);
    assign rx_slot_adv  = (rx_avail_inc == '0 || rx_slot_inc == CMP_W'(rxs)) ? '0
                                                                             : rx_slot_inc[SIZE_W-1:0];
    assign tx_slot_adv  = (tx_avail_inc == '0 || tx_slot_inc == CMP_W'(txs)) ? '0
                                                                             : tx_slot_inc[SIZE_W-1:0];

    always_comb
    begin
        if (rd_len_reg > HDR_L)
        begin
            pay_full = rd_len_reg - HDR_L;
        end
        else
        begin
            pay_full = '0;
        end
        if (pay_full > LEN_W'(maxf_reg))
        begin
            pay_clamp = maxf_reg;
        end
        else
        begin
            pay_clamp = pay_full[MAXF_W-1:0];
        end
    end

    always_comb
    begin
        status_next  = ST_NONE;
        sod_next     = '0;
        lout_next    = '0;
        rw_next      = 1'b0;
        rslot_next   = '0;
        rval_next    = '0;
        ntf_next     = NTF_NONE;
        haspay_next  = 1'b0;
        rx_slot_next = rx_slot_reg;
        tx_slot_next = tx_slot_reg;
        rx_avail_next = rx_avail_reg;
        tx_avail_next = tx_avail_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        push         = 1'b0;
        unique case (opc_reg)
            OP_RX_USED:
            begin
                priority if (desc_reg >= WORD_W'(rxs))
                begin
                    status_next = ST_DESC_OOR;
                end
                else if (count_reg >= rxs)
                begin
                    status_next   = ST_RECYCLED;
                    rw_next       = 1'b1;
                    rslot_next    = rx_slot_reg[RSLOT_W-1:0];
                    rval_next     = desc_reg[RSLOT_W-1:0];
                    ntf_next      = NTF_RX;
                    rx_avail_next = rx_avail_inc;
                    rx_slot_next  = rx_slot_adv;
                end
                else
                begin
                    status_next = ST_QUEUED;
                    push        = 1'b1;
                    tail_next   = (tail_inc == CMP_W'(rxs)) ? '0 : IDX_W'(tail_inc);
                    count_next  = count_reg + SIZE_W'(1);
                end
            end
            OP_POLL:
            begin
                if (count_reg != '0)
                begin
                    head_next  = (head_inc == CMP_W'(rxs)) ? '0 : IDX_W'(head_inc);
                    count_next = count_reg - SIZE_W'(1);
                    sod_next   = WORD_W'(rd_desc_reg);
                    if (rd_desc_reg >= rxs)
                    begin
                        status_next = ST_DESC_OOR;
                    end
                    else
                    begin
                        status_next   = ST_RETURNED;
                        lout_next     = WORD_W'(pay_clamp);
                        haspay_next   = (pay_clamp != '0);
                        rw_next       = 1'b1;
                        rslot_next    = rx_slot_reg[RSLOT_W-1:0];
                        rval_next     = rd_desc_reg[RSLOT_W-1:0];
                        ntf_next      = NTF_RX;
                        rx_avail_next = rx_avail_inc;
                        rx_slot_next  = rx_slot_adv;
                    end
                end
            end
            OP_SEND:
            begin
                priority if (flen_reg == '0 || flen_reg > WORD_W'(maxf_reg))
                begin
                    status_next = ST_BAD_LEN;
                end
                else if (outstanding >= WORD_W'(txs))
                begin
                    status_next = ST_TX_FULL;
                end
                else
                begin
                    status_next   = ST_QUEUED;
                    sod_next      = WORD_W'(tx_slot_reg);
                    lout_next     = flen_reg + HDR_W;
                    rw_next       = 1'b1;
                    rslot_next    = tx_slot_reg[RSLOT_W-1:0];
                    rval_next     = tx_slot_reg[RSLOT_W-1:0];
                    ntf_next      = NTF_TX;
                    tx_avail_next = tx_avail_inc;
                    tx_slot_next  = tx_slot_adv;
                end
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_size_reg  <= RX_SIZE_RST;
            tx_size_reg  <= TX_SIZE_RST;
            maxf_reg     <= MAXF_RST;
            rx_slot_reg  <= '0;
            tx_slot_reg  <= '0;
            rx_avail_reg <= WORD_W'(eff_size(RX_SIZE_RST));
            tx_avail_reg <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RX_SIZE:
                    begin
                        rx_size_reg  <= cfg_data[SIZE_W-1:0];
                        rx_slot_reg  <= '0;
                        rx_avail_reg <= WORD_W'(eff_size(cfg_data[SIZE_W-1:0]));
                        head_reg     <= '0;
                        tail_reg     <= '0;
                        count_reg    <= '0;
                    end
                    CFG_TX_SIZE:
                    begin
                        tx_size_reg  <= cfg_data[SIZE_W-1:0];
                        tx_slot_reg  <= '0;
                        tx_avail_reg <= '0;
                    end
                    CFG_MAXF:
                    begin
                        maxf_reg <= cfg_data[MAXF_W-1:0];
                    end
                    default:
                    begin
                        maxf_reg <= maxf_reg;
                    end
                endcase
            end
            else if (cmd.execute)
            begin
                rx_slot_reg  <= rx_slot_next;
                tx_slot_reg  <= tx_slot_next;
                rx_avail_reg <= rx_avail_next;
                tx_avail_reg <= tx_avail_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                count_reg    <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_desc_reg <= desc_mem[head_reg];
        rd_len_reg  <= len_mem[head_reg];
        if (cmd.execute && push)
        begin
            desc_mem[tail_reg] <= desc_reg[SIZE_W-1:0];
            len_mem[tail_reg]  <= ulen_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opc_reg   <= opcode;
            desc_reg  <= desc_id;
            ulen_reg  <= used_len;
            flen_reg  <= frame_length;
            dused_reg <= device_used_idx;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            sod_reg    <= sod_next;
            lout_reg   <= lout_next;
            rw_reg     <= rw_next;
            rslot_reg  <= rslot_next;
            rval_reg   <= rval_next;
            ntf_reg    <= ntf_next;
            pend_reg   <= (count_next != '0);
            haspay_reg <= haspay_next;
        end
    end

    assign status       = status_reg;
    assign slot_or_desc = sod_reg;
    assign length_out   = lout_reg;
    assign ring_write   = rw_reg;
    assign ring_slot    = rslot_reg;
    assign ring_value   = rval_reg;
    assign notify_queue = ntf_reg;
    assign rx_pending   = pend_reg;
    assign has_payload  = haspay_reg;

endmodule

// ===== rtl/net_virtqueue_ring_manager.sv =====
// Top level of the virtqueue ring manager: controller and datapath.
// Each item passes through intake, completion FIFO read and execute into the result register.
// The FIFO memory read is registered; no new item is taken in until the last one executes.
// A finished result waits in the output register while the next item is taken in.
// Reset: ring sizes 8, max frame length 1514, FIFO empty, transmit index and ring slots zero.
// The FIFO memory is not cleared; only entries that were written are ever read.
`timescale 1ns / 1ps

module net_virtqueue_ring_manager
#(
    parameter int RING_DEPTH   = nvrm_pkg::DEF_RING_DEPTH,
    parameter int HEADER_BYTES = nvrm_pkg::DEF_HEADER_BYTES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [nvrm_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [nvrm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [nvrm_pkg::OPC_W-1:0]    opcode,
    input  logic [nvrm_pkg::WORD_W-1:0]   desc_id,
    input  logic [nvrm_pkg::LEN_W-1:0]    used_len,
    input  logic [nvrm_pkg::WORD_W-1:0]   frame_length,
    input  logic [nvrm_pkg::WORD_W-1:0]   device_used_idx,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nvrm_pkg::STAT_W-1:0]   status,
    output logic [nvrm_pkg::WORD_W-1:0]   slot_or_desc,
    output logic [nvrm_pkg::WORD_W-1:0]   length_out,
    output logic                          ring_write,
    output logic [nvrm_pkg::RSLOT_W-1:0]  ring_slot,
    output logic [nvrm_pkg::RSLOT_W-1:0]  ring_value,
    output logic [nvrm_pkg::NTF_W-1:0]    notify_queue,
    output logic                          rx_pending,
    output logic                          has_payload
);
    import nvrm_pkg::*;

    ctl_cmd_t cmd;

    nvrm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    nvrm_datapath
    #(
        .RING_DEPTH   (RING_DEPTH),
        .HEADER_BYTES (HEADER_BYTES)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .desc_id         (desc_id),
        .used_len        (used_len),
        .frame_length    (frame_length),
        .device_used_idx (device_used_idx),
        .status          (status),
        .slot_or_desc    (slot_or_desc),
        .length_out      (length_out),
        .ring_write      (ring_write),
        .ring_slot       (ring_slot),
        .ring_value      (ring_value),
        .notify_queue    (notify_queue),
        .rx_pending      (rx_pending),
        .has_payload     (has_payload)
    );

endmodule

// ===== tb/nvrm_checker.sv =====
// Checker for the virtqueue ring manager: predicts every result and compares it field by field.
`timescale 1ns / 1ps

module nvrm_checker
    import nvrm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OPC_W-1:0]    opcode,
    input  logic [WORD_W-1:0]   desc_id,
    input  logic [LEN_W-1:0]    used_len,
    input  logic [WORD_W-1:0]   frame_length,
    input  logic [WORD_W-1:0]   device_used_idx,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STAT_W-1:0]   status,
    input  logic [WORD_W-1:0]   slot_or_desc,
    input  logic [WORD_W-1:0]   length_out,
    input  logic                ring_write,
    input  logic [RSLOT_W-1:0]  ring_slot,
    input  logic [RSLOT_W-1:0]  ring_value,
    input  logic [NTF_W-1:0]    notify_queue,
    input  logic                rx_pending,
    input  logic                has_payload,
    output int                  fault_count,
    output int                  results_due,
    output int                  results_checked,
    output logic [WORD_W-1:0]   tx_head
);

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [WORD_W-1:0]  slot_or_desc;
        logic [WORD_W-1:0]  length_out;
        logic               ring_write;
        logic [RSLOT_W-1:0] ring_slot;
        logic [RSLOT_W-1:0] ring_value;
        logic [NTF_W-1:0]   notify_queue;
        logic               rx_pending;
        logic               has_payload;
    } ring_result_t;

    ring_result_t ring_results_due[$];
    ring_result_t got;
    ring_result_t want;

    logic [SIZE_W-1:0] rx_size_reg;
    logic [SIZE_W-1:0] tx_size_reg;
    logic [MAXF_W-1:0] max_frame;
    logic [WORD_W-1:0] rx_avail;
    logic [WORD_W-1:0] tx_avail;
    logic [WORD_W-1:0] held_desc [DEF_RING_DEPTH];
    logic [LEN_W-1:0]  held_len  [DEF_RING_DEPTH];
    int unsigned       fifo_rd;
    int unsigned       fifo_wr;
    int unsigned       fifo_fill;

    initial
    begin
        fault_count     = 0;
        results_due     = 0;
        results_checked = 0;
    end

    assign tx_head = tx_avail;

    task automatic report_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] seen,
                               input logic [31:0] wanted);
        if (seen !== wanted)
            report_fault($sformatf("result %0d field %s = %0h, expected %0h",
                                   results_checked, name, seen, wanted));
    endtask

    function automatic int unsigned span_of(input logic [SIZE_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > DEF_RING_DEPTH)
            return DEF_RING_DEPTH;
        return v;
    endfunction

    function automatic ring_result_t predict_ring_step(
        input logic [OPC_W-1:0]  opc,
        input logic [WORD_W-1:0] desc,
        input logic [LEN_W-1:0]  ulen,
        input logic [WORD_W-1:0] flen,
        input logic [WORD_W-1:0] dused
    );
        ring_result_t      r;
        int unsigned       rxs;
        int unsigned       txs;
        int unsigned       pos;
        int unsigned       pay;
        logic [WORD_W-1:0] d;
        logic [LEN_W-1:0]  tot;
        logic [WORD_W-1:0] in_flight;
        r = '0;
        r.status = ST_NONE;
        rxs = span_of(rx_size_reg);
        txs = span_of(tx_size_reg);
        case (opc)
            OP_RX_USED:
            begin
                if (desc >= rxs)
                    r.status = ST_DESC_OOR;
                else if (fifo_fill >= rxs)
                begin
                    r.status = ST_RECYCLED;
                    r.ring_write = 1'b1;
                    r.ring_slot = RSLOT_W'(rx_avail % rxs);
                    r.ring_value = desc[RSLOT_W-1:0];
                    r.notify_queue = NTF_RX;
                    rx_avail = rx_avail + 1'b1;
                end
                else
                begin
                    pos = fifo_wr % DEF_RING_DEPTH;
                    held_desc[pos] = desc;
                    held_len[pos] = ulen;
                    fifo_wr = (fifo_wr + 1) % rxs;
                    fifo_fill++;
                    r.status = ST_QUEUED;
                end
            end
            OP_POLL:
            begin
                if (fifo_fill != 0)
                begin
                    pos = fifo_rd % DEF_RING_DEPTH;
                    d = held_desc[pos];
                    tot = held_len[pos];
                    fifo_rd = (fifo_rd + 1) % rxs;
                    fifo_fill--;
                    r.slot_or_desc = d;
                    if (d >= rxs)
                        r.status = ST_DESC_OOR;
                    else
                    begin
                        pay = 0;
                        if (tot > DEF_HEADER_BYTES)
                        begin
                            pay = tot - DEF_HEADER_BYTES;
                            if (pay > max_frame)
                                pay = max_frame;
                        end
                        r.status = ST_RETURNED;
                        r.length_out = WORD_W'(pay);
                        r.has_payload = (pay != 0);
                        r.ring_write = 1'b1;
                        r.ring_slot = RSLOT_W'(rx_avail % rxs);
                        r.ring_value = d[RSLOT_W-1:0];
                        r.notify_queue = NTF_RX;
                        rx_avail = rx_avail + 1'b1;
                    end
                end
            end
            OP_SEND:
            begin
                in_flight = tx_avail - dused;
                if (flen == 0 || flen > max_frame)
                    r.status = ST_BAD_LEN;
                else if (in_flight >= txs)
                    r.status = ST_TX_FULL;
                else
                begin
                    pos = tx_avail % txs;
                    r.status = ST_QUEUED;
                    r.slot_or_desc = WORD_W'(pos);
                    r.length_out = flen + WORD_W'(DEF_HEADER_BYTES);
                    r.ring_write = 1'b1;
                    r.ring_slot = RSLOT_W'(pos);
                    r.ring_value = RSLOT_W'(pos);
                    r.notify_queue = NTF_TX;
                    tx_avail = tx_avail + 1'b1;
                end
            end
            default:
                r.status = ST_NONE;
        endcase
        r.rx_pending = (fifo_fill != 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_size_reg = RX_SIZE_RST;
            tx_size_reg = TX_SIZE_RST;
            max_frame = MAXF_RST;
            rx_avail = WORD_W'(span_of(RX_SIZE_RST));
            tx_avail = '0;
            fifo_rd = 0;
            fifo_wr = 0;
            fifo_fill = 0;
            ring_results_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.status       = status;
                got.slot_or_desc = slot_or_desc;
                got.length_out   = length_out;
                got.ring_write   = ring_write;
                got.ring_slot    = ring_slot;
                got.ring_value   = ring_value;
                got.notify_queue = notify_queue;
                got.rx_pending   = rx_pending;
                got.has_payload  = has_payload;
                if (ring_results_due.size() == 0)
                    report_fault($sformatf("result with no item outstanding, status %0d",
                                           status));
                else
                begin
                    want = ring_results_due.pop_front();
                    check_field("status", got.status, want.status);
                    check_field("slot_or_desc", got.slot_or_desc, want.slot_or_desc);
                    check_field("length_out", got.length_out, want.length_out);
                    check_field("ring_write", got.ring_write, want.ring_write);
                    check_field("ring_slot", got.ring_slot, want.ring_slot);
                    check_field("ring_value", got.ring_value, want.ring_value);
                    check_field("notify_queue", got.notify_queue, want.notify_queue);
                    check_field("rx_pending", got.rx_pending, want.rx_pending);
                    check_field("has_payload", got.has_payload, want.has_payload);
                    results_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RX_SIZE:
                    begin
                        rx_size_reg = cfg_data[SIZE_W-1:0];
                        rx_avail = WORD_W'(span_of(rx_size_reg));
                        fifo_rd = 0;
                        fifo_wr = 0;
                        fifo_fill = 0;
                    end
                    CFG_TX_SIZE:
                    begin
                        tx_size_reg = cfg_data[SIZE_W-1:0];
                        tx_avail = '0;
                    end
                    CFG_MAXF:
                        max_frame = cfg_data[MAXF_W-1:0];
                    default:
                        ;
                endcase
            end
            if (in_valid && !in_stall)
                ring_results_due.push_back(predict_ring_step(opcode, desc_id, used_len,
                                                             frame_length, device_used_idx));
        end
        results_due = ring_results_due.size();
    end

endmodule

// ===== tb/tb_net_virtqueue_ring_manager.sv =====
// Testbench top for the virtqueue ring manager: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_net_virtqueue_ring_manager
    import nvrm_pkg::*;
;

    localparam logic [OPC_W-1:0]  OP_SPARE    = 2'd3;
    localparam logic [CIDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam int                PLAN_LEN    = 9;
    localparam int                PHASE_ITEMS = 205;
    localparam int                CYCLE_LIMIT = 400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [OPC_W-1:0]    opcode = '0;
    logic [WORD_W-1:0]   desc_id = '0;
    logic [LEN_W-1:0]    used_len = '0;
    logic [WORD_W-1:0]   frame_length = '0;
    logic [WORD_W-1:0]   device_used_idx = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [WORD_W-1:0]   slot_or_desc;
    logic [WORD_W-1:0]   length_out;
    logic                ring_write;
    logic [RSLOT_W-1:0]  ring_slot;
    logic [RSLOT_W-1:0]  ring_value;
    logic [NTF_W-1:0]    notify_queue;
    logic                rx_pending;
    logic                has_payload;

    int                  fault_count;
    int                  results_due;
    int                  results_checked;
    logic [WORD_W-1:0]   tx_head;

    int                  cycle_count = 0;
    int                  burst_left = 0;
    int                  items_sent = 0;
    int                  hold_req = 0;
    int                  hold_done = 0;

    logic [SIZE_W-1:0]   rx_plan   [PLAN_LEN];
    logic [SIZE_W-1:0]   tx_plan   [PLAN_LEN];
    logic [MAXF_W-1:0]   maxf_plan [PLAN_LEN];

    net_virtqueue_ring_manager DUT (.*);

    nvrm_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                     results_due);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off for a long
    // stretch whenever the stimulus asks for it.
    initial
    begin : receiver
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_done)
            begin
                hold_done++;
                hold = 80;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 99) < 30);
                    2:       out_stall <= (left % 3 == 0);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    // Offers one item and returns once it is accepted. With rel_used set, the device
    // used index is taken as that many entries behind the transmit avail index.
    task automatic offer(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] desc,
                         input logic [LEN_W-1:0] ulen, input logic [WORD_W-1:0] flen,
                         input logic [WORD_W-1:0] dused, input bit rel_used);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        desc_id <= desc;
        used_len <= ulen;
        frame_length <= flen;
        device_used_idx <= rel_used ? tx_head - dused : dused;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic program_regs(input logic [SIZE_W-1:0] rx, input logic [SIZE_W-1:0] tx,
                                input logic [MAXF_W-1:0] maxf, input bit with_spare);
        logic [CIDX_W-1:0] idx [4];
        logic [CFG_W-1:0]  val [4];
        int                n;
        idx[0] = CFG_MAXF;
        val[0] = CFG_W'(maxf);
        idx[1] = CFG_TX_SIZE;
        val[1] = CFG_W'(tx);
        idx[2] = CFG_RX_SIZE;
        val[2] = CFG_W'(rx);
        idx[3] = CFG_SPARE;
        val[3] = CFG_W'($urandom);
        n = with_spare ? 4 : 3;
        // Let the block settle after the last result before touching registers.
        repeat (3) @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                rx_span;
        int                tx_span;
        int                hold_at;
        int                pause_at;
        int                pick;
        int                directed;
        logic [OPC_W-1:0]  op;
        logic [WORD_W-1:0] desc;
        logic [LEN_W-1:0]  ulen;
        logic [WORD_W-1:0] flen;
        logic [WORD_W-1:0] dused;
        bit                rel;
        logic [MAXF_W-1:0] maxf;

        rx_plan   = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8, 4'd5, 4'd4};
        tx_plan   = '{4'd1, 4'd8, 4'd0, 4'd9, 4'd5, 4'd7, 4'd1, 4'd8, 4'd3};
        maxf_plan = '{11'd1, 11'd2038, 11'd2047, 11'd0, 11'd64, 11'd1514, 11'd200,
                      11'd2047, 11'd11};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings: ring sizes 8, max frame 1514.
        offer(OP_POLL, 16'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        offer(OP_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        offer(OP_RX_USED, 16'd8, 32'd100, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'hFFFF, 32'd100, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd7, 32'd10, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd3, 32'd11, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd5, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd1, 32'd1524, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd2, 32'd1525, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd4, 32'd64, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd6, 32'd2048, 16'd0, 16'd0, 1'b0);
        offer(OP_RX_USED, 16'd6, 32'd77, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < 6; i++)
            offer(OP_POLL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        offer(OP_SEND, 16'd0, 32'd0, 16'd0, 16'd0, 1'b0);
        offer(OP_SEND, 16'd0, 32'd0, 16'd1515, 16'd0, 1'b0);
        offer(OP_SEND, 16'd0, 32'd0, 16'd1514, 16'd0, 1'b0);
        offer(OP_SEND, 16'd0, 32'd0, 16'd1, 16'hFFF9, 1'b0);
        offer(OP_SEND, 16'd0, 32'd0, 16'hFFFF, 16'd0, 1'b0);
        directed = items_sent;

        for (int p = 0; p < PLAN_LEN; p++)
        begin
            drain();
            program_regs(rx_plan[p], tx_plan[p], maxf_plan[p], p == 3);
            rx_span = (rx_plan[p] == 0) ? 1 : (rx_plan[p] > 8 ? 8 : rx_plan[p]);
            tx_span = (tx_plan[p] == 0) ? 1 : (tx_plan[p] > 8 ? 8 : tx_plan[p]);
            maxf = maxf_plan[p];
            hold_at = $urandom_range(10, PHASE_ITEMS - 80);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == hold_at)
                begin
                    hold_req++;
                    burst_left = 60;
                end
                if (k == pause_at)
                    drain();

                pick = $urandom_range(0, 99);
                op = (pick < 44) ? OP_RX_USED : (pick < 74) ? OP_POLL :
                     (pick < 97) ? OP_SEND : OP_SPARE;

                pick = $urandom_range(0, 99);
                if (pick < 90)
                    desc = WORD_W'($urandom_range(0, rx_span - 1));
                else if (pick < 95)
                    desc = WORD_W'($urandom_range(rx_span, 15));
                else
                    desc = WORD_W'($urandom);

                pick = $urandom_range(0, 99);
                if (pick < 25)
                    ulen = $urandom_range(0, 12);
                else if (pick < 70)
                    ulen = $urandom_range(13, 2100);
                else if (pick < 85)
                    ulen = maxf + DEF_HEADER_BYTES + $urandom_range(0, 2) - 1;
                else
                    ulen = $urandom;

                pick = $urandom_range(0, 99);
                if (pick < 70 && maxf != 0)
                    flen = WORD_W'($urandom_range(1, maxf));
                else if (pick < 80)
                    flen = '0;
                else if (pick < 90)
                    flen = maxf + WORD_W'($urandom_range(0, 1));
                else
                    flen = WORD_W'($urandom);

                pick = $urandom_range(0, 99);
                rel = (pick < 90);
                if (pick < 80)
                    dused = WORD_W'($urandom_range(0, tx_span));
                else if (pick < 90)
                    dused = WORD_W'($urandom_range(tx_span, 40));
                else
                    dused = WORD_W'($urandom);

                offer(op, desc, ulen, flen, dused, rel);
            end
        end

        drain();
        repeat (20) @(negedge clk);

        $display("Ran %0d items (%0d directed) over %0d register settings after reset.",
                 items_sent, directed, PLAN_LEN);
        $display("Checked %0d results; %0d long output hold-offs, %0d cycles.",
                 results_checked, hold_done, cycle_count);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nvrm_pkg.sv
rtl/nvrm_ctrl.sv
rtl/nvrm_datapath.sv
rtl/net_virtqueue_ring_manager.sv
tb/nvrm_checker.sv
tb/tb_net_virtqueue_ring_manager.sv
